### sv/wgm_pkg.sv
`default_nettype none
package wgm_pkg;

  localparam int GradW   = 16;
  localparam int WeightW = 16;
  localparam int QuoW    = 16;
  localparam int DenW    = WeightW + 1;
  localparam int DvdW    = DenW + QuoW;
  localparam int ProdW   = WeightW + GradW + 1;
  localparam int SumW    = ProdW + 1;

  typedef struct packed {
    logic signed [GradW-1:0] grad_a_x;
    logic signed [GradW-1:0] grad_a_y;
    logic [WeightW-1:0]      weight_a;
    logic                    valid_a;
    logic signed [GradW-1:0] grad_b_x;
    logic signed [GradW-1:0] grad_b_y;
    logic [WeightW-1:0]      weight_b;
    logic                    valid_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [GradW-1:0] merged_x;
    logic signed [GradW-1:0] merged_y;
    logic [WeightW-1:0]      merged_weight;
    logic                    merged_valid;
  } out_beat_t;

  // products of the first stage
  typedef struct packed {
    logic signed [ProdW-1:0] prod_ax;
    logic signed [ProdW-1:0] prod_ay;
    logic signed [ProdW-1:0] prod_bx;
    logic signed [ProdW-1:0] prod_by;
    logic [2*WeightW-1:0]    prod_w;
    logic [DenW-1:0]         den;
    logic                    ok;
  } prod_t;

  // one lane of a restoring divider
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] dvd_lo;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t       x;
    div_lane_t       y;
    div_lane_t       w;
    logic [DenW-1:0] den;
    logic            neg_x;
    logic            neg_y;
    logic            ok;
  } div_t;

  // quotient is known to fit QuoW bits, so the top part starts below den
  function automatic div_lane_t div_init(logic [DvdW-1:0] dvd);
    div_lane_t res;
    res.rem    = dvd[DvdW-1:QuoW];
    res.dvd_lo = dvd[QuoW-1:0];
    res.quo    = '0;
    return res;
  endfunction

  function automatic div_lane_t div_step(div_lane_t lane, logic [DenW-1:0] den);
    logic [DenW:0] trial;
    div_lane_t     res;
    trial      = {lane.rem, lane.dvd_lo[QuoW-1]};
    res.dvd_lo = {lane.dvd_lo[QuoW-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      res.rem = DenW'(trial - {1'b0, den});
      res.quo = {lane.quo[QuoW-2:0], 1'b1};
    end else begin
      res.rem = trial[DenW-1:0];
      res.quo = {lane.quo[QuoW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### sv/wgm_front.sv
`default_nettype none
module wgm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  wgm_pkg::in_beat_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output wgm_pkg::div_t     data_o
);
  import wgm_pkg::*;

  logic  prod_valid_q;
  prod_t prod_d, prod_q;
  logic  prod_ready;
  logic  div_valid_q;
  div_t  div_d, div_q;

  logic signed [SumW-1:0] num_x, num_y;
  logic [SumW-1:0]        mag_x, mag_y;

  assign prod_ready = ~div_valid_q | ready_i;
  assign ready_o    = ~prod_valid_q | prod_ready;

  always_comb begin
    prod_d.prod_ax = $signed({1'b0, data_i.weight_a}) * $signed(data_i.grad_a_x);
    prod_d.prod_ay = $signed({1'b0, data_i.weight_a}) * $signed(data_i.grad_a_y);
    prod_d.prod_bx = $signed({1'b0, data_i.weight_b}) * $signed(data_i.grad_b_x);
    prod_d.prod_by = $signed({1'b0, data_i.weight_b}) * $signed(data_i.grad_b_y);
    prod_d.prod_w  = data_i.weight_a * data_i.weight_b;
    prod_d.den     = {1'b0, data_i.weight_a} + {1'b0, data_i.weight_b};
    prod_d.ok      = data_i.valid_a & data_i.valid_b &
                     (data_i.weight_a != '0) & (data_i.weight_b != '0);
  end

  always_comb begin
    num_x = SumW'(prod_q.prod_ax) + SumW'(prod_q.prod_bx);
    num_y = SumW'(prod_q.prod_ay) + SumW'(prod_q.prod_by);
    mag_x = num_x[SumW-1] ? SumW'(-num_x) : SumW'(num_x);
    mag_y = num_y[SumW-1] ? SumW'(-num_y) : SumW'(num_y);
    div_d.x     = div_init(mag_x[DvdW-1:0]);
    div_d.y     = div_init(mag_y[DvdW-1:0]);
    div_d.w     = div_init({prod_q.prod_w, 1'b0});
    div_d.den   = prod_q.den;
    div_d.neg_x = num_x[SumW-1];
    div_d.neg_y = num_y[SumW-1];
    div_d.ok    = prod_q.ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      div_valid_q  <= 1'b0;
    end else begin
      if (ready_o) prod_valid_q <= valid_i;
      if (prod_ready) div_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) prod_q <= prod_d;
    if (prod_ready && prod_valid_q) div_q <= div_d;
  end

  assign valid_o = div_valid_q;
  assign data_o  = div_q;

endmodule
`default_nettype wire

### sv/wgm_div_step.sv
`default_nettype none
module wgm_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wgm_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wgm_pkg::div_t data_o
);
  import wgm_pkg::*;

  logic valid_q;
  div_t data_d, data_q;

  assign ready_o = ~valid_q | ready_i;

  // one quotient bit for each of the three lanes
  always_comb begin
    data_d   = data_i;
    data_d.x = div_step(data_i.x, data_i.den);
    data_d.y = div_step(data_i.y, data_i.den);
    data_d.w = div_step(data_i.w, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

### sv/wgm_back.sv
`default_nettype none
module wgm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  wgm_pkg::div_t      data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output wgm_pkg::out_beat_t data_o
);
  import wgm_pkg::*;

  logic      valid_q;
  out_beat_t data_d, data_q;
  logic      keep;

  assign ready_o = ~valid_q | ready_i;

  // restore signs, drop everything on an invalid merge
  always_comb begin
    keep = data_i.ok & (data_i.w.quo != '0);
    data_d.merged_x      = '0;
    data_d.merged_y      = '0;
    data_d.merged_weight = '0;
    data_d.merged_valid  = 1'b0;
    if (keep) begin
      data_d.merged_x      = data_i.neg_x ? GradW'(-data_i.x.quo) : GradW'(data_i.x.quo);
      data_d.merged_y      = data_i.neg_y ? GradW'(-data_i.y.quo) : GradW'(data_i.y.quo);
      data_d.merged_weight = WeightW'(data_i.w.quo);
      data_d.merged_valid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

### sv/weighted_gradient_merge.sv
// Path: front product and setup registers, the divider stages, the back register.
// Throughput: one beat per cycle unless the output stalls; each of the 16 divider
// stages retires one quotient bit; a stage advances when the next one can accept.
// Reset: asynchronous, active low; clears all stage valid bits, data is not reset.
`default_nettype none
module weighted_gradient_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wgm_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wgm_pkg::out_beat_t out_beat_o
);
  import wgm_pkg::*;

  logic [QuoW:0] stg_valid;
  logic [QuoW:0] stg_ready;
  div_t          stg_data [QuoW+1];

  wgm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_beat_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    wgm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[i]),
      .ready_o (stg_ready[i]),
      .data_i  (stg_data[i]),
      .valid_o (stg_valid[i+1]),
      .ready_i (stg_ready[i+1]),
      .data_o  (stg_data[i+1])
    );
  end

  wgm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[QuoW]),
    .ready_o (stg_ready[QuoW]),
    .data_i  (stg_data[QuoW]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_beat_o)
  );

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import wgm_pkg::*;

  localparam int NumRandom = 1900;
  localparam int CalmTail  = 300;
  localparam int Limit     = 400000;
  localparam int DrainWait = 40;
  localparam int HoldStart = 2500;
  localparam int HoldLen   = 400;

  typedef struct {
    in_beat_t  stim;
    bit        typed;
    out_beat_t want;
  } row_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_beat_t out_beat_o;

  out_beat_t merge_queue[$];
  row_t      plan[$];
  bit        calm     = 1'b0;
  int        idle_pct = 0;
  int        errors   = 0;
  int        cycles   = 0;
  int        n_sent   = 0;
  int        n_merged = 0;
  int        n_valid  = 0;

  weighted_gradient_merge dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic in_beat_t pixel(int ax, int ay, int wa, bit va,
                                     int bx, int by, int wb, bit vb);
    in_beat_t p;
    p.grad_a_x = GradW'(ax);
    p.grad_a_y = GradW'(ay);
    p.weight_a = WeightW'(wa);
    p.valid_a  = va;
    p.grad_b_x = GradW'(bx);
    p.grad_b_y = GradW'(by);
    p.weight_b = WeightW'(wb);
    p.valid_b  = vb;
    return p;
  endfunction

  function automatic out_beat_t merged(int x, int y, int w, bit v);
    out_beat_t r;
    r.merged_x      = GradW'(x);
    r.merged_y      = GradW'(y);
    r.merged_weight = WeightW'(w);
    r.merged_valid  = v;
    return r;
  endfunction

  // harmonic mean weight and weighted mean slope, truncated toward zero
  function automatic out_beat_t merge_pixel(in_beat_t p);
    longint    wa;
    longint    wb;
    longint    hw;
    longint    sx;
    longint    sy;
    out_beat_t r;
    r  = '0;
    wa = longint'(p.weight_a);
    wb = longint'(p.weight_b);
    if (!p.valid_a || !p.valid_b || wa == 0 || wb == 0) return r;
    hw = (2 * wa * wb) / (wa + wb);
    if (hw == 0) return r;
    sx = (wa * longint'($signed(p.grad_a_x)) + wb * longint'($signed(p.grad_b_x))) / (wa + wb);
    sy = (wa * longint'($signed(p.grad_a_y)) + wb * longint'($signed(p.grad_b_y))) / (wa + wb);
    r.merged_x      = GradW'(sx);
    r.merged_y      = GradW'(sy);
    r.merged_weight = WeightW'(hw);
    r.merged_valid  = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] rand_slope();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(0, 15) == 0) return 16'h0000;
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 255));
      1: return 16'($urandom_range(65280, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_beat_t rand_pixel();
    in_beat_t p;
    p.grad_a_x = rand_slope();
    p.grad_a_y = rand_slope();
    p.weight_a = rand_weight();
    p.valid_a  = ($urandom_range(0, 15) != 0);
    p.grad_b_x = rand_slope();
    p.grad_b_y = rand_slope();
    p.weight_b = rand_weight();
    p.valid_b  = ($urandom_range(0, 15) != 0);
    return p;
  endfunction

  // hold valid until the beat is taken, then queue what it must produce
  task automatic offer(input in_beat_t b, input bit typed, input out_beat_t want);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    merge_queue.push_back(typed ? want : merge_pixel(b));
    n_sent++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == Limit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (merge_queue.size() == 0) begin
        $error("unexpected result beat: x %0d y %0d weight %0d valid %0b",
               out_beat_o.merged_x, out_beat_o.merged_y,
               out_beat_o.merged_weight, out_beat_o.merged_valid);
        errors++;
      end else begin
        want = merge_queue.pop_front();
        n_merged++;
        if (want.merged_valid) n_valid++;
        if (out_beat_o.merged_x !== want.merged_x) begin
          $error("merged_x: expected %0d, got %0d", want.merged_x, out_beat_o.merged_x);
          errors++;
        end
        if (out_beat_o.merged_y !== want.merged_y) begin
          $error("merged_y: expected %0d, got %0d", want.merged_y, out_beat_o.merged_y);
          errors++;
        end
        if (out_beat_o.merged_weight !== want.merged_weight) begin
          $error("merged_weight: expected %0d, got %0d",
                 want.merged_weight, out_beat_o.merged_weight);
          errors++;
        end
        if (out_beat_o.merged_valid !== want.merged_valid) begin
          $error("merged_valid: expected %0b, got %0b",
                 want.merged_valid, out_beat_o.merged_valid);
          errors++;
        end
      end
    end
  end

  // receiver: short random stalls plus one long hold so the pipe backs up
  initial begin
    int stall_left;
    int rx_cycles;
    stall_left = 0;
    rx_cycles  = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rx_cycles == HoldStart) stall_left = HoldLen;
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    out_beat_t none;
    none = '0;

    plan.push_back('{pixel(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    plan.push_back('{pixel(100, -200, 512, 0, 300, 400, 768, 1), 1'b1, none});
    plan.push_back('{pixel(100, -200, 512, 1, 300, 400, 768, 0), 1'b1, none});
    plan.push_back('{pixel(100, -200, 0, 1, 300, 400, 768, 1), 1'b1, none});
    plan.push_back('{pixel(100, -200, 512, 1, 300, 400, 0, 1), 1'b1, none});
    plan.push_back('{pixel(-1, 1, 0, 1, 7, -7, 0, 1), 1'b1, none});
    plan.push_back('{pixel(32767, -1, 65535, 0, 5, 9, 65535, 0), 1'b1, none});
    plan.push_back('{pixel(32767, 32767, 65535, 1, 32767, 32767, 65535, 1),
                     1'b1, merged(32767, 32767, 65535, 1)});
    plan.push_back('{pixel(-32768, -32768, 65535, 1, -32768, -32768, 65535, 1),
                     1'b1, merged(-32768, -32768, 65535, 1)});
    plan.push_back('{pixel(-32768, -32768, 1, 1, -32768, -32768, 1, 1),
                     1'b1, merged(-32768, -32768, 1, 1)});
    // mixed signs: truncation toward zero lands on 0
    plan.push_back('{pixel(32767, -32768, 1, 1, -32768, 32767, 1, 1),
                     1'b1, merged(0, 0, 1, 1)});
    plan.push_back('{pixel(-3, 3, 1, 1, 0, 0, 1, 1), 1'b1, merged(-1, 1, 1, 1)});
    plan.push_back('{pixel(256, 256, 256, 1, 768, -256, 256, 1),
                     1'b1, merged(512, 0, 256, 1)});
    plan.push_back('{pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1),
                     1'b1, merged(-1, -1, 65535, 1)});
    plan.push_back('{pixel(32767, -32768, 1, 1, -32768, 32767, 65535, 1), 1'b0, none});
    plan.push_back('{pixel(32767, -32768, 65535, 1, -32768, 32767, 1, 1), 1'b0, none});
    plan.push_back('{pixel(16'hAAAA, 16'h5555, 16'hAAAA, 1, 16'h5555, 16'hAAAA, 16'h5555, 1),
                     1'b0, none});
    plan.push_back('{pixel(16'h5555, 16'hAAAA, 16'h5555, 1, 16'hAAAA, 16'h5555, 16'hAAAA, 1),
                     1'b0, none});
    plan.push_back('{pixel(1000, -1000, 1, 1, -999, 999, 2, 1), 1'b0, none});
    plan.push_back('{pixel(-12345, 23456, 32768, 1, 30000, -30000, 65535, 1), 1'b0, none});
    plan.push_back('{pixel(1, -1, 65535, 1, 0, 0, 65534, 1), 1'b0, none});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer(plan[i].stim, plan[i].typed, plan[i].want);

    for (int i = 0; i < NumRandom; i++) begin
      // switch at random between quiet and busy stretches
      if (i % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (i == NumRandom - CalmTail) calm = 1'b1;
      offer(rand_pixel(), 1'b0, none);
    end
    in_valid <= 1'b0;

    while (merge_queue.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("merged %0d pixel beats (%0d directed), %0d results checked",
             n_sent, plan.size(), n_merged);
    $display("%0d results valid, %0d invalid, one long output hold of %0d cycles",
             n_valid, n_merged - n_valid, HoldLen);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
